@@ rtl/core/rafg_pkg.sv @@
package rafg_pkg;

    // field widths
    localparam int STATE_W   = 64;
    localparam int COUNT_W   = 16;
    localparam int BATCH_W   = 7;
    localparam int OPCODE_W  = 1;

    // stream data widths, padded to whole bytes
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 104;

    // batch limit
    localparam logic [BATCH_W-1:0] MAX_BATCH = 7'd64;

    // input kinds
    localparam logic [OPCODE_W-1:0] OP_LOAD = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_DRAW = 1'b1;

    // mixing constants
    localparam logic [STATE_W-1:0] MIX_MULT = 64'h9E37_79B9_7F4A_7C15;
    localparam int SHL_AMT = 7;
    localparam int SHR_AMT = 9;

    // multiplier digit size and step count
    localparam int DIGIT_W   = 16;
    localparam int MUL_STEPS = STATE_W / DIGIT_W;

endpackage

@@ rtl/core/random_action_field_generator.sv @@
// random action field generator
//
// input stream: tuser carries the opcode (load or draw), tdata carries the
// seed in bits 63..0 and the batch size in bits 70..64. a load replaces the
// 64-bit generator state in the cycle it is accepted and gives no output.
// a draw of n items (n above 64 counts as 64, n of zero gives nothing)
// produces n output items, tlast marking the final one of the batch.
// config channel: a write sets the 16-bit action count used as modulus of
// the action id; write it only while no draw is in progress.
// per action: an xorshift step, a shared 64x16 multiplier stepping through
// the constant (one constant digit a cycle), a bit-serial remainder unit
// (skipped when the action count is 0 or 1) and a step to load the output
// register. the input is not ready during a draw and is ready again once
// the last item sits in the output register. a stalled receiver holds the
// sequencer in its emit step.
// reset clears the state to zero, the action count to one, and drops
// any pending output item.
module random_action_field_generator
(
    input  logic                               clk,
    input  logic                               rst_n,
    // slave stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [63:0] seed_value, [70:64] batch_size, [71] zero
    input  logic [rafg_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [0] opcode
    input  logic [rafg_pkg::OPCODE_W-1:0]      s_axis_tuser,
    // master stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [1:0] scale, [3:2] token_op, [5:4] step_op, [7:6] struct_op,
    // [13:8] first_index, [19:14] second_index, [20] payload_is_x,
    // [36:21] action_id, [100:37] seed_after, [103:101] zero
    output logic [rafg_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast,
    // config write
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rafg_pkg::COUNT_W-1:0]       cfg_data
);
    import rafg_pkg::*;

    // sequencer codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MIX  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    localparam logic [3:0] MUL_LAST = 4'(MUL_STEPS - 1);
    localparam logic [3:0] DIV_LAST = 4'(COUNT_W - 1);

    logic [2:0]           state_reg, state_next;
    logic [STATE_W-1:0]   gen_state_reg, gen_state_next;
    logic [STATE_W-1:0]   mix_reg, mix_next;
    logic [STATE_W-1:0]   acc_reg, acc_next;
    logic [COUNT_W-1:0]   rem_reg, rem_next;
    logic [3:0]           cnt_reg, cnt_next;
    logic [BATCH_W-1:0]   left_reg, left_next;
    logic [COUNT_W-1:0]   count_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [STATE_W-1:0]   out_state_reg, out_state_next;
    logic [COUNT_W-1:0]   out_id_reg, out_id_next;
    logic                 out_last_reg, out_last_next;

    logic                 in_fire;
    logic                 out_free;
    logic [BATCH_W-1:0]   batch_in;
    logic [BATCH_W-1:0]   batch_sat;
    logic [STATE_W-1:0]   xs1, xs2;
    logic [DIGIT_W-1:0]   digit;
    logic [STATE_W+DIGIT_W-1:0] prod;
    logic [STATE_W-1:0]   partial;
    logic [STATE_W-1:0]   acc_sum;
    logic [COUNT_W:0]     rem_sh;
    logic                 div_bit;

    // handshakes
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // batch size with saturation
    assign batch_in  = s_axis_tdata[STATE_W +: BATCH_W];
    assign batch_sat = (batch_in > MAX_BATCH) ? MAX_BATCH : batch_in;

    // xorshift pair
    assign xs1 = gen_state_reg ^ (gen_state_reg << SHL_AMT);
    assign xs2 = xs1 ^ (xs1 >> SHR_AMT);

    // shared multiplier: one 16-bit digit of the constant a step
    assign digit   = MIX_MULT[{cnt_reg[1:0], 4'b0000} +: DIGIT_W];
    assign prod    = mix_reg * digit;
    assign partial = prod[STATE_W-1:0] << {cnt_reg[1:0], 4'b0000};
    assign acc_sum = acc_reg + partial;

    // restoring remainder step, msb of the low 16 bits first
    assign div_bit = gen_state_reg[{2'b00, ~cnt_reg}];
    assign rem_sh  = {rem_reg, div_bit};

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        gen_state_next = gen_state_reg;
        mix_next       = mix_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg;
        out_state_next = out_state_reg;
        out_id_next    = out_id_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_axis_tuser == OP_LOAD)
                    begin
                        gen_state_next = s_axis_tdata[STATE_W-1:0];
                    end
                    else if (batch_sat != '0)
                    begin
                        left_next  = batch_sat;
                        state_next = ST_MIX;
                    end
                end
            end
            ST_MIX:
            begin
                mix_next   = xs2;
                acc_next   = '0;
                cnt_next   = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                acc_next = acc_sum;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == MUL_LAST)
                begin
                    gen_state_next = acc_sum;
                    cnt_next       = '0;
                    rem_next       = '0;
                    state_next     = (count_reg > 16'd1) ? ST_DIV : ST_EMIT;
                end
            end
            ST_DIV:
            begin
                if (rem_sh >= {1'b0, count_reg})
                begin
                    rem_next = COUNT_W'(rem_sh - {1'b0, count_reg});
                end
                else
                begin
                    rem_next = rem_sh[COUNT_W-1:0];
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_state_next = gen_state_reg;
                    out_id_next    = rem_reg;
                    out_last_next  = (left_reg == 7'd1);
                    left_next      = left_reg - 7'd1;
                    state_next     = (left_reg == 7'd1) ? ST_IDLE : ST_MIX;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gen_state_reg <= '0;
            count_reg     <= 16'd1;
            cnt_reg       <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_state_reg <= gen_state_next;
            cnt_reg       <= cnt_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mix_reg       <= mix_next;
        acc_reg       <= acc_next;
        rem_reg       <= rem_next;
        out_state_reg <= out_state_next;
        out_id_reg    <= out_id_next;
        out_last_reg  <= out_last_next;
    end

    // output packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {
        3'b000,
        out_state_reg,
        out_id_reg,
        out_state_reg[0],
        out_state_reg[20:15],
        out_state_reg[14:9],
        out_state_reg[8:7],
        out_state_reg[6:5],
        out_state_reg[4:3],
        out_state_reg[1:0]
    };

    // remainder unit only runs with a real modulus and stays below it
    a_div_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (count_reg > 16'd1 && rem_reg < count_reg))
        else $error("remainder out of range during division");

    // a pending action always has batch budget left
    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MIX || state_reg == ST_MUL || state_reg == ST_DIV
         || state_reg == ST_EMIT) |-> (left_reg != '0))
        else $error("sequencer active with empty batch");

    // emitting the last item returns the sequencer to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free && left_reg == 7'd1)
        |=> (state_reg == ST_IDLE && out_valid_reg && out_last_reg))
        else $error("last item did not end the batch");

    // a delivered id is below the modulus when one is set
    a_id_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && count_reg > 16'd1) |-> (out_id_reg < count_reg))
        else $error("action id not reduced");

    // no new input while a batch is in flight
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tuser == OP_DRAW && batch_sat != '0)
        |=> !s_axis_tready)
        else $error("input accepted during a draw");

endmodule
